// ===== src/stx_length_etx_packet_framer_defines.svh =====
// ----------------------------------------------------------------------------
// Framer assertion macros
// Shared concurrent assertion forms for the packet framer RTL.
// ----------------------------------------------------------------------------
`ifndef STX_LENGTH_ETX_PACKET_FRAMER_DEFINES_SVH
`define STX_LENGTH_ETX_PACKET_FRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define SLEPF_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define SLEPF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/slepf_pkg.sv =====
// ----------------------------------------------------------------------------
// Packet framer package
// Codes, register indexes, reset values and the result record of the framer.
// ----------------------------------------------------------------------------
package slepf_pkg;

   // Pattern window depth in bytes
   localparam int PATTERN_MAX_DEF = 4;

   // Field widths
   localparam int LEN_W     = 3;
   localparam int REG_IDX_W = 3;
   localparam int CSR_W     = 32;
   localparam int CNT_W     = 18;
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // Register indexes
   localparam logic [REG_IDX_W-1:0] REG_START_LEN   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_START_BYTES = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_END_LEN     = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_END_BYTES   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_LEN_SIZE    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_MAX_PAYLOAD = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_CHECK_LEN   = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_VARIABLE    = 3'd7;

   // Register reset values
   localparam logic [LEN_W-1:0] RST_START_LEN   = 3'd2;
   localparam logic [31:0]      RST_START_BYTES = 32'h0000_55AA;
   localparam logic [LEN_W-1:0] RST_END_LEN     = 3'd0;
   localparam logic [31:0]      RST_END_BYTES   = 32'h0000_0000;
   localparam logic [LEN_W-1:0] RST_LEN_SIZE    = 3'd1;
   localparam logic [15:0]      RST_MAX_PAYLOAD = 16'd255;
   localparam logic [LEN_W-1:0] RST_CHECK_LEN   = 3'd1;
   localparam logic             RST_VARIABLE    = 1'b0;

   // Byte classes
   localparam logic [2:0] CLS_DISCARD = 3'd0;
   localparam logic [2:0] CLS_START   = 3'd1;
   localparam logic [2:0] CLS_LENGTH  = 3'd2;
   localparam logic [2:0] CLS_PAYLOAD = 3'd3;
   localparam logic [2:0] CLS_CHECK   = 3'd4;
   localparam logic [2:0] CLS_END     = 3'd5;

   // Packet status codes
   localparam logic [2:0] ST_NONE     = 3'd0;
   localparam logic [2:0] ST_GOOD     = 3'd1;
   localparam logic [2:0] ST_OVERSIZE = 3'd2;
   localparam logic [2:0] ST_MISMATCH = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;

   // One result record
   typedef struct packed {
      logic [7:0] data;
      logic [2:0] cls;
      logic       last;
      logic [2:0] status;
   } slepf_rsp_type;

endpackage

// ===== src/stx_length_etx_packet_framer.sv =====
// ----------------------------------------------------------------------------
// STX / length / ETX packet framer
// Byte-serial deframer that classes every received byte and marks frame ends.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while the skid entry is free and comes
// back registered as a record of the byte, its class (start, length, payload,
// checksum, end pattern or discarded), a frame-end mark and, on that mark, the
// packet status. The rate is set by the framing state (phase, start and tail
// windows, byte counter, payload size) being updated on each accepted byte;
// a two-entry output buffer parks one result on output stall. The user must
// write configuration through the csr port only while no transfer is in flight;
// the block does not enforce it. Checksum bytes are counted but not checked.
`include "stx_length_etx_packet_framer_defines.svh"

module stx_length_etx_packet_framer #(
   parameter int PATTERN_MAX = slepf_pkg::PATTERN_MAX_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // input stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] data_byte
   // result stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [15:0]                    rsp_tdata,   // [7:0] out_byte, [10:8] packet_status
   output logic [2:0]                     rsp_tuser,   // [2:0] byte_class
   output logic                           rsp_tlast,   // frame_end
   // configuration writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [slepf_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [slepf_pkg::CSR_W-1:0]     csr_data
);
   import slepf_pkg::*;

   localparam int PW = 8 * PATTERN_MAX;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_LEN,
      PH_COUNTED,
      PH_DELIM
   } phase_type;

   // configuration registers
   logic [LEN_W-1:0] cfg_start_len_ff;
   logic [31:0]      cfg_start_bytes_ff;
   logic [LEN_W-1:0] cfg_end_len_ff;
   logic [31:0]      cfg_end_bytes_ff;
   logic [LEN_W-1:0] cfg_len_size_ff;
   logic [15:0]      cfg_max_payload_ff;
   logic [LEN_W-1:0] cfg_check_len_ff;
   logic             cfg_variable_ff;

   // framing state
   phase_type        phase_ff, phase_in;
   logic [PW-1:0]    swin_ff, swin_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]      psize_ff, psize_in;
   logic [PW-1:0]    twin_ff, twin_in;

   // output buffer
   slepf_rsp_type    rsp_ff, skid_ff, result_in;
   logic             rsp_valid_ff, skid_valid_ff;

   logic             accept;
   logic [7:0]       in_byte;
   logic [LEN_W-1:0] sl, el;
   logic [3:0]       sl4;
   logic [63:0]      start64, end64;
   logic [PW-1:0]    start_ext;
   logic [CNT_W-1:0] cnt_bump;
   logic [PW-1:0]    tail_shift;

   // hunt path
   logic [3:0]       hk_raw, hk;
   logic [PW-1:0]    hsh, hwin;
   logic             hmatch, hdone;

   // length and counted paths
   logic [CNT_W-1:0] lj;
   logic [31:0]      lpay;
   logic [CNT_W-1:0] base, chk_end, total, pos;
   logic [PW-1:0]    twin_cnt;

   // mask of the lowest n bytes of a window
   function automatic logic [PW-1:0] byte_mask(input logic [3:0] n);
      logic [PW-1:0] m;
      m = '0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         m[8*i +: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
      end
      return m;
   endfunction

   // newest n window bytes equal the end pattern, first pattern byte oldest
   function automatic logic tail_match(input logic [PW-1:0] win, input logic [LEN_W-1:0] n,
                                       input logic [63:0] pat);
      logic       ok;
      logic [2:0] idx;
      ok = 1'b1;
      for (int p = 0; p < PATTERN_MAX; p++) begin
         idx = 3'(n - 3'd1 - 3'(p));
         if (4'(p) < {1'b0, n}) begin
            if (win[8*p +: 8] != pat[{idx, 3'b000} +: 8]) begin
               ok = 1'b0;
            end
         end
      end
      return ok;
   endfunction

   assign accept     = req_tvalid & req_tready;
   assign in_byte    = req_tdata[7:0];
   assign req_tready = ~skid_valid_ff;
   assign csr_ready  = 1'b1;

   // saturate pattern lengths to the window depth
   assign sl  = ({1'b0, cfg_start_len_ff} > 4'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                             : cfg_start_len_ff;
   assign el  = ({1'b0, cfg_end_len_ff} > 4'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                           : cfg_end_len_ff;
   assign sl4 = {1'b0, sl};

   assign start64    = {32'h0, cfg_start_bytes_ff};
   assign end64      = {32'h0, cfg_end_bytes_ff};
   assign cnt_bump   = (cnt_ff < CNT_MAX) ? cnt_ff + 1'b1 : cnt_ff;
   assign tail_shift = (twin_ff << 8) | PW'(in_byte);

   // start pattern as wide as the window
   always_comb begin
      start_ext = '0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         start_ext[8*i +: 8] = start64[8*i +: 8];
      end
   end

   // extend the matched start prefix by the new byte
   always_comb begin
      hk_raw = {1'b0, cnt_ff[2:0]};
      if (hk_raw >= sl4) begin
         hsh = swin_ff >> {hk_raw - sl4 + 4'd1, 3'b000};
         hk  = sl4 - 4'd1;
      end else begin
         hsh = swin_ff;
         hk  = hk_raw;
      end
      hwin   = hsh | (PW'(in_byte) << {hk, 3'b000});
      hmatch = ((hwin ^ start_ext) & byte_mask(hk + 4'd1)) == '0;
      hdone  = (hk + 4'd1) == sl4;
   end

   // length byte placement and counted-frame thresholds
   always_comb begin
      lj   = cnt_ff - CNT_W'(sl);
      lpay = psize_ff;
      if ((cnt_ff >= CNT_W'(sl)) && (lj < CNT_W'(4))) begin
         lpay = psize_ff | (32'(in_byte) << {lj[1:0], 3'b000});
      end
      base    = CNT_W'(sl) + CNT_W'(cfg_len_size_ff) + CNT_W'(psize_ff[15:0]);
      chk_end = base + CNT_W'(cfg_check_len_ff);
      total   = chk_end + CNT_W'(el);
      pos     = cnt_bump - 1'b1;
   end

   // next framing state and result for the accepted byte
   always_comb begin
      phase_in  = phase_ff;
      swin_in   = swin_ff;
      cnt_in    = cnt_ff;
      psize_in  = psize_ff;
      twin_in   = twin_ff;
      twin_cnt  = twin_ff;
      result_in.data   = in_byte;
      result_in.cls    = CLS_DISCARD;
      result_in.last   = 1'b0;
      result_in.status = ST_NONE;

      case (phase_ff)
         PH_HUNT: begin
            if (sl == '0) begin
               swin_in = '0;
               cnt_in  = '0;
            end else if (hmatch) begin
               result_in.cls = CLS_START;
               if (hdone) begin
                  swin_in  = '0;
                  twin_in  = '0;
                  cnt_in   = CNT_W'(sl);
                  psize_in = '0;
                  if (cfg_len_size_ff != '0) begin
                     phase_in = PH_LEN;
                  end else if (cfg_variable_ff) begin
                     phase_in = PH_DELIM;
                  end else begin
                     phase_in = PH_COUNTED;
                     psize_in = {16'h0, cfg_max_payload_ff};
                  end
               end else begin
                  swin_in = hwin;
                  cnt_in  = CNT_W'(hk + 4'd1);
               end
            end else begin
               swin_in = hwin >> 8;
               cnt_in  = CNT_W'(hk);
            end
         end

         PH_LEN: begin
            cnt_in        = cnt_bump;
            result_in.cls = CLS_LENGTH;
            psize_in      = lpay;
            if (cnt_bump >= CNT_W'(sl) + CNT_W'(cfg_len_size_ff)) begin
               phase_in = PH_COUNTED;
               case (cfg_len_size_ff)
                  3'd1:    psize_in = lpay & 32'h0000_00FF;
                  3'd2:    psize_in = lpay & 32'h0000_FFFF;
                  3'd4:    psize_in = lpay;
                  default: psize_in = 32'd1;
               endcase
            end
         end

         PH_COUNTED: begin
            cnt_in = cnt_bump;
            if (psize_ff > {16'h0, cfg_max_payload_ff}) begin
               result_in.cls    = CLS_DISCARD;
               result_in.last   = 1'b1;
               result_in.status = ST_OVERSIZE;
            end else begin
               if (pos < base) begin
                  result_in.cls = CLS_PAYLOAD;
               end else if (pos < chk_end) begin
                  result_in.cls = CLS_CHECK;
               end else if (pos < total) begin
                  result_in.cls = CLS_END;
                  twin_cnt      = tail_shift;
               end
               twin_in = twin_cnt;
               if (cnt_bump >= total) begin
                  result_in.last   = 1'b1;
                  result_in.status = tail_match(twin_cnt, el, end64) ? ST_GOOD : ST_MISMATCH;
               end
            end
         end

         PH_DELIM: begin
            cnt_in        = cnt_bump;
            twin_in       = tail_shift;
            result_in.cls = CLS_PAYLOAD;
            if (cnt_bump >= CNT_W'(sl) + CNT_W'(el) + 1'b1) begin
               if (tail_match(tail_shift, el, end64)) begin
                  result_in.last   = 1'b1;
                  result_in.status = ST_GOOD;
                  result_in.cls    = (el != '0) ? CLS_END : CLS_PAYLOAD;
               end else if (cnt_bump >= CNT_W'(sl) + CNT_W'(cfg_max_payload_ff)
                                         + CNT_W'(el)) begin
                  result_in.last   = 1'b1;
                  result_in.status = ST_OVERFLOW;
               end
            end
         end

         default: begin
            phase_in = PH_HUNT;
         end
      endcase

      // closed or aborted frame: drop back to hunting
      if (result_in.last) begin
         phase_in = PH_HUNT;
         swin_in  = '0;
         cnt_in   = '0;
         psize_in = '0;
         twin_in  = '0;
      end
   end

   // hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_start_len_ff   <= RST_START_LEN;
         cfg_start_bytes_ff <= RST_START_BYTES;
         cfg_end_len_ff     <= RST_END_LEN;
         cfg_end_bytes_ff   <= RST_END_BYTES;
         cfg_len_size_ff    <= RST_LEN_SIZE;
         cfg_max_payload_ff <= RST_MAX_PAYLOAD;
         cfg_check_len_ff   <= RST_CHECK_LEN;
         cfg_variable_ff    <= RST_VARIABLE;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_START_LEN:   cfg_start_len_ff   <= csr_data[LEN_W-1:0];
            REG_START_BYTES: cfg_start_bytes_ff <= csr_data[31:0];
            REG_END_LEN:     cfg_end_len_ff     <= csr_data[LEN_W-1:0];
            REG_END_BYTES:   cfg_end_bytes_ff   <= csr_data[31:0];
            REG_LEN_SIZE:    cfg_len_size_ff    <= csr_data[LEN_W-1:0];
            REG_MAX_PAYLOAD: cfg_max_payload_ff <= csr_data[15:0];
            REG_CHECK_LEN:   cfg_check_len_ff   <= csr_data[LEN_W-1:0];
            REG_VARIABLE:    cfg_variable_ff    <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // advance framing state and the output buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         swin_ff       <= '0;
         cnt_ff        <= '0;
         psize_ff      <= '0;
         twin_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            swin_ff  <= swin_in;
            cnt_ff   <= cnt_in;
            psize_ff <= psize_in;
            twin_ff  <= twin_in;
         end
         if (!rsp_valid_ff || rsp_tready) begin
            // output free: refill from skid first, else from the new byte
            if (skid_valid_ff) begin
               rsp_ff        <= skid_ff;
               rsp_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               rsp_ff       <= result_in;
               rsp_valid_ff <= accept;
            end
         end else if (accept) begin
            // output stalled: park the new result
            skid_ff       <= result_in;
            skid_valid_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_ff.status, rsp_ff.data};
   assign rsp_tuser  = rsp_ff.cls;
   assign rsp_tlast  = rsp_ff.last;

   // checks on buffer order and result coding
   `SLEPF_ASSERT_IMPLIES(a_skid_behind_output, clock, reset, skid_valid_ff, rsp_valid_ff, "skid entry without output entry")
   `SLEPF_ASSERT_NEXT(a_stall_parks_result, clock, reset, accept && rsp_valid_ff && !rsp_tready, skid_valid_ff, "stalled transfer not parked")
   `SLEPF_ASSERT_IMPLIES(a_status_on_end_only, clock, reset, rsp_valid_ff && !rsp_ff.last, rsp_ff.status == ST_NONE, "status without frame end")
   `SLEPF_ASSERT_IMPLIES(a_hunt_count_bound, clock, reset, phase_ff == PH_HUNT, cnt_ff < CNT_W'(PATTERN_MAX), "hunt prefix beyond window")

endmodule
